[rtl/ray_box_closest_hit_top_assert.svh]
// Assertion macros for the ray/box closest hit block.
// Used by the port checker; needs i_clk and i_rst_n in scope.
`ifndef RAY_BOX_CLOSEST_HIT_TOP_ASSERT_SVH
`define RAY_BOX_CLOSEST_HIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define RBCH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbch port check failed");

// Next-cycle implication, disabled in reset
`define RBCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbch port check failed");

`endif

[rtl/rbch_pkg.sv]
// Shared types and constants for the ray/box closest hit block.
// No dependencies.
package rbch_pkg;

    // Request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;

    // Configuration register indexes
    localparam logic CFG_BOX_COUNT = 1'b0;
    localparam logic CFG_MAX_DIST  = 1'b1;

    localparam int CNT_W  = 9;
    localparam int DIST_W = 31;
    localparam int IDX_W  = 13;

    localparam logic [DIST_W-1:0] DEFAULT_MAX_DIST = 31'd6553600;
    localparam logic [63:0]       T_LIMIT          = 64'h4000_0000_0000_0000;
    localparam int                EPS_Q            = 7;
    localparam int                FACE_TOL_Q       = 655;

    // Face codes
    localparam logic [2:0] FACE_NONE  = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_X = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Y = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;
    localparam logic [2:0] FACE_POS_Z = 3'd6;

    localparam logic [2:0] FACE_LOW  [3] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};
    localparam logic [2:0] FACE_HIGH [3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};

    // Multiplier operand select
    typedef enum logic [1:0] {
        MSEL_LO  = 2'd0,
        MSEL_HI  = 2'd1,
        MSEL_HIT = 2'd2
    } t_mul_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     mem_wr;
        logic     latch_ray;
        logic     div_start;
        logic     rcp_store;
        logic     axis_clr;
        logic     axis_inc;
        logic     box_init;
        logic     rd_en;
        logic     slab_init;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     t1_store;
        logic     slab_update;
        logic     win;
        logic     pos_store;
        logic     face_update;
        logic     idx_inc;
        logic     out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic flat;
        logic flat_out;
        logic slab_reject;
        logic last_axis;
        logic idx_end;
        logic closer;
    } t_stat;

endpackage

[rtl/rbch_div.sv]
// Iterative reciprocal unit: 2^32 / divisor, one quotient bit per cycle.
// Depends on nothing; used by rbch_dp.
module rbch_div #(
    parameter int CB = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CB-1:0] i_divisor,
    output logic          o_done,
    output logic [CB-1:0] o_quot
);
    localparam int QW = (CB > 33) ? CB : 33;
    localparam logic [QW-1:0] QMAX = QW'((64'd1 << (CB - 1)) - 64'd1);

    logic [CB-1:0] r_m;
    logic [CB-1:0] r_rem;
    logic [32:0]   r_q;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [CB:0]   w_trial;
    logic          w_ge;
    logic [QW-1:0] w_qx;

    // Restoring step; the dividend has its only set bit on the first step
    assign w_trial = {r_rem, (r_cnt == 6'd33)};
    assign w_ge    = w_trial >= {1'b0, r_m};
    assign w_qx    = QW'(r_q);
    assign o_quot  = (w_qx > QMAX) ? QMAX[CB-1:0] : w_qx[CB-1:0];
    assign o_done  = r_done;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? CB'(w_trial - {1'b0, r_m}) : w_trial[CB-1:0];
            r_q   <= {r_q[31:0], w_ge};
        end
    end

endmodule

[rtl/rbch_mul.sv]
// Digit-serial multiplier: 16 bits of operand B per cycle, then >>16 and
// saturation to +-2^62. Depends on rbch_pkg; used by rbch_dp.
module rbch_mul #(
    parameter int MW = 33
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MW-1:0]      i_a,
    input  logic [MW-1:0]      i_b,
    input  logic               i_neg,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    import rbch_pkg::*;

    localparam int ND = (MW + 15) / 16;
    localparam int BW = ND * 16;
    localparam int PW = MW + BW;
    localparam int SW = (PW - 16 > 64) ? PW - 16 : 64;
    localparam int CW = $clog2(ND + 1);

    logic [MW-1:0]      r_a;
    logic [BW-1:0]      r_b;
    logic [PW-1:0]      r_acc;
    logic               r_neg;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic signed [63:0] r_res;

    logic [MW+15:0] w_pp;
    logic [PW-1:0]  w_acc_n;
    logic [SW-1:0]  w_sh;
    logic [63:0]    w_mag;

    // One partial product per cycle, top digit first
    assign w_pp    = r_a * r_b[BW-1 -: 16];
    assign w_acc_n = {r_acc[PW-17:0], 16'd0} + PW'(w_pp);

    // Drop the fraction and clamp the magnitude
    assign w_sh  = SW'(r_acc[PW-1:16]);
    assign w_mag = (w_sh > SW'(T_LIMIT)) ? T_LIMIT : w_sh[63:0];

    assign o_done = r_done;
    assign o_res  = r_res;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ND);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // Operands, accumulator, result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BW'(i_b);
            r_neg <= i_neg;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= w_acc_n;
            r_b   <= {r_b[BW-17:0], 16'd0};
        end else if (r_fin) begin
            r_res <= r_neg ? -$signed(w_mag) : $signed(w_mag);
        end
    end

endmodule

[rtl/rbch_dp.sv]
// Datapath: box store, configuration, slab arithmetic, hit point and face.
// Depends on rbch_pkg, rbch_div and rbch_mul.
module rbch_dp #(
    parameter int MAX_BOXES = 256,
    parameter int CB        = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [rbch_pkg::DIST_W-1:0]  i_cfg_data,
    input  rbch_pkg::t_cmd               i_cmd,
    output rbch_pkg::t_stat              o_stat,
    input  logic [7:0]                   i_slot,
    input  logic signed [CB-1:0]         i_a_x,
    input  logic signed [CB-1:0]         i_a_y,
    input  logic signed [CB-1:0]         i_a_z,
    input  logic signed [CB-1:0]         i_b_x,
    input  logic signed [CB-1:0]         i_b_y,
    input  logic signed [CB-1:0]         i_b_z,
    output logic                         o_hit,
    output logic signed [CB-1:0]         o_hit_x,
    output logic signed [CB-1:0]         o_hit_y,
    output logic signed [CB-1:0]         o_hit_z,
    output logic [2:0]                   o_face
);
    import rbch_pkg::*;

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int MW = (CB + 1 > 32) ? CB + 1 : 32;
    localparam int EW = 6 * CB;
    localparam logic signed [64:0] PMAX = (65'sd1 <<< (CB - 1)) - 65'sd1;
    localparam logic signed [64:0] PMIN = -PMAX - 65'sd1;

    // Ray, reciprocals, configuration
    logic signed [CB-1:0] r_a [3];
    logic signed [CB-1:0] r_b [3];
    logic [CB-1:0]        r_rmag [3];
    logic [CNT_W-1:0]     r_box_count;
    logic [DIST_W-1:0]    r_max_dist;

    // Box store and current box
    logic [EW-1:0] r_mem [MAX_BOXES];
    logic [EW-1:0] r_box;

    logic [IDX_W-1:0]     r_idx;
    logic [1:0]           r_axis;
    logic signed [63:0]   r_tmin;
    logic signed [63:0]   r_tmax;
    logic signed [63:0]   r_closest;
    logic signed [63:0]   r_t1;
    logic                 r_hit;
    logic signed [CB-1:0] r_pos [3];
    logic [2:0]           r_face;

    logic signed [CB-1:0] w_lo [3];
    logic signed [CB-1:0] w_hi [3];
    logic signed [CB-1:0] w_sa, w_sb, w_slo, w_shi;
    logic [CB-1:0]        w_bmag;
    logic signed [CB:0]   w_dlo, w_dhi, w_dsel;
    logic [CB:0]          w_dmag;
    logic [MW-1:0]        w_mul_a, w_mul_b;
    logic                 w_mul_neg;
    logic                 w_div_done, w_mul_done;
    logic [CB-1:0]        w_quot;
    logic signed [63:0]   w_res;
    logic signed [63:0]   w_tl, w_th, w_ntmin, w_ntmax;
    logic signed [64:0]   w_sum;
    logic signed [CB-1:0] w_psat;
    logic [2:0]           w_face_n;
    logic [IDX_W-1:0]     w_n;
    logic [IDX_W-1:0]     w_slot_ext;
    logic signed [CB:0]   w_fd_lo [3];
    logic signed [CB:0]   w_fd_hi [3];
    logic [CB:0]          w_fa_lo [3];
    logic [CB:0]          w_fa_hi [3];

    // Box corners from the read register
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_lo[k] = r_box[k*CB +: CB];
            w_hi[k] = r_box[(k+3)*CB +: CB];
        end
    end

    // Current axis selection
    assign w_sa   = r_a[r_axis];
    assign w_sb   = r_b[r_axis];
    assign w_slo  = w_lo[r_axis];
    assign w_shi  = w_hi[r_axis];
    assign w_bmag = w_sb[CB-1] ? (~w_sb + 1'b1) : w_sb;

    // Slab distances to the corner planes
    assign w_dlo  = {w_slo[CB-1], w_slo} - {w_sa[CB-1], w_sa};
    assign w_dhi  = {w_shi[CB-1], w_shi} - {w_sa[CB-1], w_sa};
    assign w_dsel = (i_cmd.mul_sel == MSEL_HI) ? w_dhi : w_dlo;
    assign w_dmag = w_dsel[CB] ? (~w_dsel + 1'b1) : w_dsel;

    // Multiplier operand mux
    always_comb begin
        case (i_cmd.mul_sel)
            MSEL_HIT: begin
                w_mul_a   = MW'(w_bmag);
                w_mul_b   = MW'(r_tmin[DIST_W-1:0]);
                w_mul_neg = w_sb[CB-1];
            end
            default: begin
                w_mul_a   = MW'(w_dmag);
                w_mul_b   = MW'(r_rmag[r_axis]);
                w_mul_neg = w_dsel[CB] ^ w_sb[CB-1];
            end
        endcase
    end

    rbch_div #(.CB(CB)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (w_bmag),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    rbch_mul #(.MW(MW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_neg   (w_mul_neg),
        .o_done  (w_mul_done),
        .o_res   (w_res)
    );

    // Slab interval update
    assign w_tl    = (r_t1 > w_res) ? w_res : r_t1;
    assign w_th    = (r_t1 > w_res) ? r_t1 : w_res;
    assign w_ntmin = (w_tl > r_tmin) ? w_tl : r_tmin;
    assign w_ntmax = (w_th < r_tmax) ? w_th : r_tmax;

    // Hit point with saturation
    assign w_sum  = {{(65-CB){w_sa[CB-1]}}, w_sa} + {w_res[63], w_res};
    assign w_psat = (w_sum > PMAX) ? PMAX[CB-1:0] :
                    (w_sum < PMIN) ? PMIN[CB-1:0] : w_sum[CB-1:0];

    // Face pick, -x first
    always_comb begin
        w_face_n = r_face;
        for (int k = 2; k >= 0; k--) begin
            w_fd_lo[k] = {r_pos[k][CB-1], r_pos[k]} - {w_lo[k][CB-1], w_lo[k]};
            w_fd_hi[k] = {r_pos[k][CB-1], r_pos[k]} - {w_hi[k][CB-1], w_hi[k]};
            w_fa_lo[k] = w_fd_lo[k][CB] ? (~w_fd_lo[k] + 1'b1) : w_fd_lo[k];
            w_fa_hi[k] = w_fd_hi[k][CB] ? (~w_fd_hi[k] + 1'b1) : w_fd_hi[k];
            if (w_fa_hi[k] < (CB+1)'(FACE_TOL_Q)) begin
                w_face_n = FACE_HIGH[k];
            end
            if (w_fa_lo[k] < (CB+1)'(FACE_TOL_Q)) begin
                w_face_n = FACE_LOW[k];
            end
        end
    end

    // Boxes examined per cast
    assign w_n = (IDX_W'(r_box_count) > IDX_W'(MAX_BOXES)) ? IDX_W'(MAX_BOXES)
                                                          : IDX_W'(r_box_count);
    assign w_slot_ext = IDX_W'(i_slot);

    // Status
    always_comb begin
        o_stat.div_done    = w_div_done;
        o_stat.mul_done    = w_mul_done;
        o_stat.flat        = w_bmag < CB'(EPS_Q);
        o_stat.flat_out    = (w_sa < w_slo) || (w_sa > w_shi);
        o_stat.slab_reject = w_ntmin > w_ntmax;
        o_stat.last_axis   = r_axis == 2'd2;
        o_stat.idx_end     = r_idx >= w_n;
        o_stat.closer      = r_tmin < r_closest;
    end

    // Box store write
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && (w_slot_ext < IDX_W'(MAX_BOXES))) begin
            r_mem[w_slot_ext[AW-1:0]] <= {i_b_z, i_b_y, i_b_x, i_a_z, i_a_y, i_a_x};
        end
    end

    // Box store read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_box <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count <= '0;
            r_max_dist  <= DEFAULT_MAX_DIST;
            r_idx       <= '0;
            r_axis      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BOX_COUNT: r_box_count <= i_cfg_data[CNT_W-1:0];
                    CFG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                    default:       r_max_dist  <= r_max_dist;
                endcase
            end
            if (i_cmd.box_init) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.axis_clr) begin
                r_axis <= 2'd0;
            end else if (i_cmd.axis_inc) begin
                r_axis <= r_axis + 2'd1;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_ray) begin
            r_a[0] <= i_a_x;
            r_a[1] <= i_a_y;
            r_a[2] <= i_a_z;
            r_b[0] <= i_b_x;
            r_b[1] <= i_b_y;
            r_b[2] <= i_b_z;
        end
        if (i_cmd.rcp_store) begin
            r_rmag[r_axis] <= w_quot;
        end
        if (i_cmd.box_init) begin
            r_closest <= 64'(r_max_dist);
            r_hit     <= 1'b0;
            r_face    <= FACE_NONE;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
            end
        end
        if (i_cmd.slab_init) begin
            r_tmin <= '0;
            r_tmax <= 64'(r_max_dist);
        end
        if (i_cmd.t1_store) begin
            r_t1 <= w_res;
        end
        if (i_cmd.slab_update) begin
            r_tmin <= w_ntmin;
            r_tmax <= w_ntmax;
        end
        if (i_cmd.win) begin
            r_closest <= r_tmin;
            r_hit     <= 1'b1;
        end
        if (i_cmd.pos_store) begin
            r_pos[r_axis] <= w_psat;
        end
        if (i_cmd.face_update) begin
            r_face <= w_face_n;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_hit   <= r_hit;
            o_hit_x <= r_pos[0];
            o_hit_y <= r_pos[1];
            o_hit_z <= r_pos[2];
            o_face  <= r_face;
        end
    end

endmodule

[rtl/rbch_ctrl.sv]
// Controller state machine: sequences reciprocals, the box walk, slab tests,
// hit point and face. Depends on rbch_pkg.
module rbch_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_operation,
    output logic            o_ready,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output rbch_pkg::t_cmd  o_cmd,
    input  rbch_pkg::t_stat i_stat
);
    import rbch_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RCP   = 14'b00000000000010,
        S_RWT   = 14'b00000000000100,
        S_BINIT = 14'b00000000001000,
        S_NEXT  = 14'b00000000010000,
        S_AXIS  = 14'b00000000100000,
        S_M1    = 14'b00000001000000,
        S_M2    = 14'b00000010000000,
        S_JUDGE = 14'b00000100000000,
        S_HP    = 14'b00001000000000,
        S_HPW   = 14'b00010000000000,
        S_FACE  = 14'b00100000000000,
        S_ADV   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;

    assign o_res_valid = r_res_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_operation == OP_CAST) begin
                        o_cmd.latch_ray = 1'b1;
                        o_cmd.axis_clr  = 1'b1;
                        n_state         = S_RCP;
                    end else begin
                        o_cmd.mem_wr = 1'b1;
                    end
                end
            end
            S_RCP: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_RWT;
            end
            S_RWT: begin
                if (i_stat.div_done) begin
                    o_cmd.rcp_store = 1'b1;
                    if (i_stat.last_axis) begin
                        n_state = S_BINIT;
                    end else begin
                        o_cmd.axis_inc = 1'b1;
                        n_state        = S_RCP;
                    end
                end
            end
            S_BINIT: begin
                o_cmd.box_init = 1'b1;
                n_state        = S_NEXT;
            end
            S_NEXT: begin
                if (i_stat.idx_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.axis_clr  = 1'b1;
                    o_cmd.slab_init = 1'b1;
                    n_state         = S_AXIS;
                end
            end
            S_AXIS: begin
                if (i_stat.flat) begin
                    if (i_stat.flat_out) begin
                        n_state = S_ADV;
                    end else if (i_stat.last_axis) begin
                        n_state = S_JUDGE;
                    end else begin
                        o_cmd.axis_inc = 1'b1;
                    end
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_LO;
                    n_state         = S_M1;
                end
            end
            S_M1: begin
                if (i_stat.mul_done) begin
                    o_cmd.t1_store  = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_HI;
                    n_state         = S_M2;
                end
            end
            S_M2: begin
                if (i_stat.mul_done) begin
                    o_cmd.slab_update = 1'b1;
                    if (i_stat.slab_reject) begin
                        n_state = S_ADV;
                    end else if (i_stat.last_axis) begin
                        n_state = S_JUDGE;
                    end else begin
                        o_cmd.axis_inc = 1'b1;
                        n_state        = S_AXIS;
                    end
                end
            end
            S_JUDGE: begin
                if (i_stat.closer) begin
                    o_cmd.win      = 1'b1;
                    o_cmd.axis_clr = 1'b1;
                    n_state        = S_HP;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_HP: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MSEL_HIT;
                n_state         = S_HPW;
            end
            S_HPW: begin
                o_cmd.mul_sel = MSEL_HIT;
                if (i_stat.mul_done) begin
                    o_cmd.pos_store = 1'b1;
                    if (i_stat.last_axis) begin
                        n_state = S_FACE;
                    end else begin
                        o_cmd.axis_inc = 1'b1;
                        n_state        = S_HP;
                    end
                end
            end
            S_FACE: begin
                o_cmd.face_update = 1'b1;
                n_state           = S_ADV;
            end
            S_ADV: begin
                o_cmd.idx_inc = 1'b1;
                n_state       = S_NEXT;
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb begin
        n_res_valid = r_res_valid;
        if (o_cmd.out_load) begin
            n_res_valid = 1'b1;
        end else if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

[rtl/ray_box_closest_hit_top.sv]
// Top level of the ray/box closest hit block.
// Depends on rbch_pkg, rbch_ctrl and rbch_dp.
//
//  channel   valid        ready        payload
//  request   i_valid      o_ready      i_operation, i_slot, i_a_*, i_b_*
//  result    o_res_valid  i_res_ready  o_hit, o_hit_x/y/z, o_face
//  config    i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load request writes the box store from idle. A cast first forms the three
// reciprocals (33-step divider) and sets up, then per box reads the store and
// tests each axis: a flat axis by a compare, a sloped axis by two products. A
// box that passes the slab test is judged; when it becomes the nearest, three
// more products give the hit point and the face is updated. Then the result is
// loaded. ND = 3 digits at 32 bits for the shared serial multiplier.
// Reset is synchronous; no clearing pass, the box store is not initialized.
// A waiting result does not block load requests; a cast holds in its last
// state until the output register is free. Config writes are taken when idle.
module ray_box_closest_hit_top #(
    parameter int MAX_BOXES  = 256,
    parameter int COORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic [7:0]                          i_slot,
    input  logic signed [COORD_BITS-1:0]        i_a_x,
    input  logic signed [COORD_BITS-1:0]        i_a_y,
    input  logic signed [COORD_BITS-1:0]        i_a_z,
    input  logic signed [COORD_BITS-1:0]        i_b_x,
    input  logic signed [COORD_BITS-1:0]        i_b_y,
    input  logic signed [COORD_BITS-1:0]        i_b_z,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_hit,
    output logic signed [COORD_BITS-1:0]        o_hit_x,
    output logic signed [COORD_BITS-1:0]        o_hit_y,
    output logic signed [COORD_BITS-1:0]        o_hit_z,
    output logic [2:0]                          o_face,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [rbch_pkg::DIST_W-1:0]         i_cfg_data
);
    import rbch_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Configuration writes are taken only while no cast is running
    assign o_cfg_ready = o_ready;

    rbch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    rbch_dp #(
        .MAX_BOXES (MAX_BOXES),
        .CB        (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_slot      (i_slot),
        .i_a_x       (i_a_x),
        .i_a_y       (i_a_y),
        .i_a_z       (i_a_z),
        .i_b_x       (i_b_x),
        .i_b_y       (i_b_y),
        .i_b_z       (i_b_z),
        .o_hit       (o_hit),
        .o_hit_x     (o_hit_x),
        .o_hit_y     (o_hit_y),
        .o_hit_z     (o_hit_z),
        .o_face      (o_face)
    );

endmodule

[rtl/rbch_checker.sv]
// Port checker for the ray/box closest hit block, bound to the top level.
// Depends on rbch_pkg and ray_box_closest_hit_top_assert.svh.
`include "ray_box_closest_hit_top_assert.svh"

module rbch_checker #(
    parameter int COORD_BITS = 32
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        i_operation,
    input logic                        o_res_valid,
    input logic                        i_res_ready,
    input logic                        o_hit,
    input logic signed [COORD_BITS-1:0] o_hit_x,
    input logic signed [COORD_BITS-1:0] o_hit_y,
    input logic signed [COORD_BITS-1:0] o_hit_z,
    input logic [2:0]                  o_face
);
    import rbch_pkg::*;

    // A stalled result holds its valid, hit flag, x coordinate and face
    `RBCH_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready, o_res_valid && $stable(o_hit) && $stable(o_hit_x) && $stable(o_face))

    // A miss reports zero point and no face
    `RBCH_ASSERT_NOW(a_miss_zero, o_res_valid && !o_hit, o_hit_x == 0 && o_hit_y == 0 && o_hit_z == 0 && o_face == FACE_NONE)

    // A cast request makes the block busy
    `RBCH_ASSERT_NEXT(a_cast_busy, i_valid && o_ready && i_operation == OP_CAST, !o_ready)

    // Face code stays in range
    `RBCH_ASSERT_NOW(a_face_range, o_res_valid, o_face <= FACE_POS_Z)

endmodule

bind ray_box_closest_hit_top rbch_checker #(.COORD_BITS(COORD_BITS)) u_rbch_checker (.*);

[tb/sv/ray_box_closest_hit_top_tb.sv]
// Testbench for ray_box_closest_hit_top: box loads, ray casts, config phases.
// Depends on rbch_pkg and the RTL of the block; needs no files or arguments.
module ray_box_closest_hit_top_tb;
    import rbch_pkg::*;

    localparam int NBOX      = 256;
    localparam int WD_LIMIT  = 200000;
    localparam int ONE       = 65536;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [2:0]         face;
    } hit_res_t;

    typedef enum logic [1:0] { ROW_LOAD, ROW_CAST, ROW_CFG } row_kind_e;

    // one directed row; miss = 1 means the result must be an empty miss
    typedef struct {
        row_kind_e kind;
        int        slot;
        int        ax, ay, az, bx, by, bz;
        logic      miss;
    } row_t;

    localparam hit_res_t NO_HIT = '{hit: 1'b0, x: '0, y: '0, z: '0, face: FACE_NONE};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_operation = OP_LOAD;
    logic [7:0]         i_slot = '0;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic               o_res_valid;
    logic               i_res_ready = 1'b0;
    logic               o_hit;
    logic signed [31:0] o_hit_x, o_hit_y, o_hit_z;
    logic [2:0]         o_face;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_BOX_COUNT;
    logic [DIST_W-1:0]  i_cfg_data = '0;

    ray_box_closest_hit_top u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow state of the block
    longint   box_lo [3][NBOX];
    longint   box_hi [3][NBOX];
    int       box_count_q = 0;
    longint   max_dist_q  = DEFAULT_MAX_DIST;

    hit_res_t pending_hits [$];
    int       errors = 0;
    int       n_loads = 0, n_casts = 0, n_results = 0, n_cfg = 0, n_hits = 0;
    bit       no_idle = 1'b0;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // exact product >> 16, truncated toward zero, saturated at 2^62
    function automatic longint mul_q16(longint a, longint b);
        logic [127:0]    p;
        longint unsigned r;
        p = 128'(magnitude(a)) * 128'(magnitude(b));
        p = p >> 16;
        r = (p > 128'(T_LIMIT)) ? T_LIMIT : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint recip_q16(longint d);
        longint unsigned q;
        q = 64'h1_0000_0000 / magnitude(d);
        if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // Closest slab hit over the first box_count boxes
    function automatic hit_res_t trace_ray(longint org[3], longint dir[3]);
        hit_res_t res;
        longint   closest, tmin, tmax, t1, t2, r, tmp;
        longint   pos[3];
        int       n;
        bit       rej, any;
        logic [2:0] face;
        closest = max_dist_q;
        any = 1'b0;
        face = FACE_NONE;
        pos = '{0, 0, 0};
        n = box_count_q > NBOX ? NBOX : box_count_q;
        for (int i = 0; i < n; i++) begin
            tmin = 0;
            tmax = max_dist_q;
            rej = 1'b0;
            for (int k = 0; k < 3 && !rej; k++) begin
                if (magnitude(dir[k]) < EPS_Q) begin
                    if (org[k] < box_lo[k][i] || org[k] > box_hi[k][i]) rej = 1'b1;
                end else begin
                    r  = recip_q16(dir[k]);
                    t1 = mul_q16(box_lo[k][i] - org[k], r);
                    t2 = mul_q16(box_hi[k][i] - org[k], r);
                    if (t1 > t2) begin
                        tmp = t1; t1 = t2; t2 = tmp;
                    end
                    if (t1 > tmin) tmin = t1;
                    if (t2 < tmax) tmax = t2;
                    if (tmin > tmax) rej = 1'b1;
                end
            end
            if (rej || tmin >= closest) continue;
            closest = tmin;
            any = 1'b1;
            for (int k = 0; k < 3; k++) pos[k] = sat32(org[k] + mul_q16(dir[k], tmin));
            // first face plane within tolerance; else keep the previous face
            for (int k = 0; k < 3; k++) begin
                if (magnitude(pos[k] - box_lo[k][i]) < FACE_TOL_Q) begin
                    face = FACE_LOW[k];
                    break;
                end
                if (magnitude(pos[k] - box_hi[k][i]) < FACE_TOL_Q) begin
                    face = FACE_HIGH[k];
                    break;
                end
            end
        end
        if (!any) return NO_HIT;
        res.hit  = 1'b1;
        res.x    = pos[0][31:0];
        res.y    = pos[1][31:0];
        res.z    = pos[2][31:0];
        res.face = face;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request, wait for acceptance, update the shadow state
    task automatic send_req(logic op, int slot, int ax, int ay, int az,
                            int bx, int by, int bz, logic force_miss);
        longint org[3];
        longint dir[3];
        int     gap;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_slot      <= slot[7:0];
        i_a_x <= ax; i_a_y <= ay; i_a_z <= az;
        i_b_x <= bx; i_b_y <= by; i_b_z <= bz;
        do @(posedge i_clk); while (!o_ready);
        org = '{ax, ay, az};
        dir = '{bx, by, bz};
        if (op == OP_LOAD) begin
            for (int k = 0; k < 3; k++) begin
                box_lo[k][slot[7:0]] = org[k];
                box_hi[k][slot[7:0]] = dir[k];
            end
            n_loads++;
        end else begin
            pending_hits.insert(pending_hits.size(),
                                force_miss ? NO_HIT : trace_ray(org, dir));
            n_casts++;
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender stops and waits for every result, then waits out a last load
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, int unsigned data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[DIST_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BOX_COUNT) box_count_q = data & 32'h1ff;
        else max_dist_q = data & 32'h7fff_ffff;
        n_cfg++;
    endtask

    // Random box: mostly small well-formed, some inverted or full range
    task automatic load_random(int slot);
        int c[3], h[3], lo[3], hi[3], r;
        r = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) begin
            c[k]  = $urandom_range(0, 80 * ONE) - 40 * ONE;
            h[k]  = $urandom_range(ONE / 4, 8 * ONE);
            lo[k] = c[k] - h[k];
            hi[k] = c[k] + h[k];
            if (r >= 90) begin
                lo[k] = $urandom();
                hi[k] = $urandom();
            end else if (r >= 85 && k == 1) begin
                lo[k] = c[k] + h[k];
                hi[k] = c[k] - h[k];
            end
        end
        send_req(OP_LOAD, slot, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], 1'b0);
    endtask

    // Random ray, mostly aimed at one of the examined boxes
    task automatic cast_random();
        int     org[3], dir[3], tgt, n, r, sh;
        longint ctr;
        n = box_count_q > NBOX ? NBOX : box_count_q;
        r = $urandom_range(0, 99);
        tgt = (n > 0) ? $urandom_range(0, n - 1) : 0;
        sh = $urandom_range(3, 8);
        for (int k = 0; k < 3; k++) begin
            ctr    = (box_lo[k][tgt] + box_hi[k][tgt]) / 2;
            org[k] = $urandom_range(0, 120 * ONE) - 60 * ONE;
            dir[k] = int'((ctr - org[k]) >>> sh);
            if (r >= 88 || n == 0) begin
                org[k] = $urandom();
                dir[k] = $urandom();
            end else if ($urandom_range(0, 9) == 0) begin
                // nearly flat axis, origin inside the slab half the time
                dir[k] = $urandom_range(0, 12) - 6;
                if ($urandom_range(0, 1)) org[k] = int'(ctr);
            end
        end
        send_req(OP_CAST, 0, org[0], org[1], org[2], dir[0], dir[1], dir[2], 1'b0);
    endtask

    // Result side back-pressure
    int stall_left = 0;
    always @(posedge i_clk) begin
        int r;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_res_ready <= 1'b0;
        end else if (no_idle) begin
            i_res_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_res_ready <= 1'b1;
            end else begin
                i_res_ready <= 1'b0;
                stall_left <= (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 60);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        hit_res_t got, want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got = '{hit: o_hit, x: o_hit_x, y: o_hit_y, z: o_hit_z, face: o_face};
            n_results++;
            if (o_hit) n_hits++;
            if (pending_hits.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result %p", got);
            end else begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit || got.x !== want.x || got.y !== want.y
                    || got.z !== want.z || got.face !== want.face) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result %0d expected %p got %p",
                                 n_results, want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request, result or write
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_res_valid && i_res_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WD_LIMIT) begin
            $display("timeout: no progress for %0d cycles", WD_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    localparam int MIN32 = 32'sh8000_0000;
    localparam int MAX32 = 32'sh7fff_ffff;

    // Directed table: loads, casts and register writes in order
    row_t directed [] = '{
        '{ROW_CAST, 0, 0, 0, 0, ONE, 0, 0, 1'b1},
        '{ROW_LOAD, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0},
        '{ROW_LOAD, 1, 10*ONE, -2*ONE, -2*ONE, 12*ONE, 2*ONE, 2*ONE, 1'b0},
        '{ROW_LOAD, 2, 5*ONE, ONE, ONE, 3*ONE, -ONE, -ONE, 1'b0},
        '{ROW_LOAD, 3, -ONE, -ONE, -ONE, ONE, ONE, ONE, 1'b0},
        '{ROW_LOAD, 255, MIN32, MIN32, MIN32, MAX32, MAX32, MAX32, 1'b0},
        '{ROW_CFG, CFG_BOX_COUNT, 4, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_CAST, 0, -5*ONE, 0, 0, ONE, 0, 0, 1'b0},
        '{ROW_CAST, 0, 0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_CAST, 0, 20*ONE, 0, 0, -ONE, 0, 0, 1'b0},
        '{ROW_CAST, 0, 0, -5*ONE, 0, 0, ONE, 0, 1'b0},
        '{ROW_CAST, 0, 0, 0, 5*ONE, 0, 0, -ONE, 1'b0},
        '{ROW_CAST, 0, 8*ONE, 0, 0, -ONE, 6, 0, 1'b0},
        '{ROW_CAST, 0, MAX32, MIN32, MAX32, MIN32, MAX32, MIN32, 1'b0},
        '{ROW_CAST, 0, -5*ONE, ONE/2, 0, ONE, 3*ONE, 0, 1'b0},
        '{ROW_CFG, CFG_MAX_DIST, 0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_CAST, 0, -5*ONE, 0, 0, ONE, 0, 0, 1'b1},
        '{ROW_CFG, CFG_MAX_DIST, MAX32, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_CAST, 0, -5*ONE, 0, 0, ONE, 0, 0, 1'b0},
        '{ROW_CAST, 0, MIN32, MIN32, MIN32, ONE, ONE, ONE, 1'b0},
        '{ROW_CFG, CFG_MAX_DIST, DEFAULT_MAX_DIST, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_CAST, 0, 0, 0, 0, 6, -6, 6, 1'b0}
    };

    initial begin
        int n_phase_items, cnt;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            case (directed[i].kind)
                ROW_CFG: begin
                    write_cfg(directed[i].slot[0], directed[i].ax);
                end
                default: begin
                    send_req(directed[i].kind == ROW_CAST ? OP_CAST : OP_LOAD,
                             directed[i].slot, directed[i].ax, directed[i].ay,
                             directed[i].az, directed[i].bx, directed[i].by,
                             directed[i].bz, directed[i].miss);
                end
            endcase
        end

        // fill the whole store so any box count reads written slots only
        for (int s = 0; s < NBOX; s++) load_random(s);

        // count beyond the store examines every slot
        write_cfg(CFG_BOX_COUNT, 300);
        cast_random();
        cast_random();

        // random phases with new settings each time
        for (int ph = 0; ph < 14; ph++) begin
            case ($urandom_range(0, 9))
                0:       cnt = $urandom_range(256, 511);
                1:       cnt = 0;
                default: cnt = $urandom_range(1, 16);
            endcase
            write_cfg(CFG_BOX_COUNT, cnt);
            case ($urandom_range(0, 5))
                0:       write_cfg(CFG_MAX_DIST, 0);
                1:       write_cfg(CFG_MAX_DIST, MAX32);
                2:       write_cfg(CFG_MAX_DIST, $urandom_range(ONE, 40 * ONE));
                3:       write_cfg(CFG_MAX_DIST, $urandom() >> 1);
                default: write_cfg(CFG_MAX_DIST, DEFAULT_MAX_DIST);
            endcase
            no_idle = (ph % 5 == 3);
            n_phase_items = 20;
            for (int j = 0; j < n_phase_items; j++) begin
                if ($urandom_range(0, 99) < ((box_count_q > 32) ? 4 : 22)) cast_random();
                else load_random($urandom_range(0, NBOX - 1));
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d loads, %0d casts, %0d config writes;", n_loads, n_casts,
                 n_cfg);
        $display("%0d results checked, %0d of them hits, %0d mismatches.", n_results,
                 n_hits, errors);
        if (errors == 0 && pending_hits.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rbch_pkg.sv
rtl/rbch_div.sv
rtl/rbch_mul.sv
rtl/rbch_dp.sv
rtl/rbch_ctrl.sv
rtl/ray_box_closest_hit_top.sv
rtl/rbch_checker.sv
tb/sv/ray_box_closest_hit_top_tb.sv
